// ===== rtl/rmq_pkg.sv =====
// ----------------------------------------------------------------------------
// rmq_pkg
// shared widths, limits, slot codes and control struct for the rotation
// matrix to quaternion pipeline
// ----------------------------------------------------------------------------
package rmq_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int IN_W          = 18;
  localparam int OUT_W         = 18;
  localparam int NUM_W         = 19;
  localparam int QB            = 19;
  localparam int NSLOT         = 4;

  // quaternion slots
  localparam int SLOT_W = 0;
  localparam int SLOT_X = 1;
  localparam int SLOT_Y = 2;
  localparam int SLOT_Z = 3;

  localparam logic [QB-1:0] MAG_POS = QB'(131071);
  localparam logic [QB-1:0] MAG_NEG = QB'(131072);
  localparam logic [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

  typedef struct packed {
    logic [NSLOT-1:0][NUM_W-1:0] num;
    logic [NSLOT-1:0]            slot;
    logic                        inv;
  } rmq_ctl_t;

endpackage

// ===== rtl/rotation_matrix_to_quaternion.sv =====
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion
// 3x3 rotation matrix (signed fixed point) to quaternion, fully pipelined
// ----------------------------------------------------------------------------
// usage:
//   input channel in_valid/in_stall carries the nine matrix entries in_r00 ..
//   in_r22; a transfer takes place when in_valid is high and in_stall low.
//   result channel out_valid/out_stall carries out_qw, out_qx, out_qy, out_qz
//   and out_invalid, one result per input transfer, in order.
//   throughput: one matrix per cycle while the output is not stalled.
//   the square root has SW bit stages, SW = ceil((max(FRAC_BITS,19)+2+FRAC_BITS)/2);
//   the divider adds 19 bit stages.
//   the whole pipeline advances as one; while out_valid is high and out_stall
//   is high every stage holds and in_stall is raised, nothing is lost.
//   reset clears all stage valid bits; no result is pending afterwards.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion #(
  parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic signed [rmq_pkg::IN_W-1:0]  in_r00,
  input  logic signed [rmq_pkg::IN_W-1:0]  in_r01,
  input  logic signed [rmq_pkg::IN_W-1:0]  in_r02,
  input  logic signed [rmq_pkg::IN_W-1:0]  in_r10,
  input  logic signed [rmq_pkg::IN_W-1:0]  in_r11,
  input  logic signed [rmq_pkg::IN_W-1:0]  in_r12,
  input  logic signed [rmq_pkg::IN_W-1:0]  in_r20,
  input  logic signed [rmq_pkg::IN_W-1:0]  in_r21,
  input  logic signed [rmq_pkg::IN_W-1:0]  in_r22,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [rmq_pkg::OUT_W-1:0] out_qw,
  output logic signed [rmq_pkg::OUT_W-1:0] out_qx,
  output logic signed [rmq_pkg::OUT_W-1:0] out_qy,
  output logic signed [rmq_pkg::OUT_W-1:0] out_qz,
  output logic                             out_invalid
);
  import rmq_pkg::*;

  localparam int RW  = ((FRAC_BITS > 19) ? FRAC_BITS : 19) + 2;
  localparam int AW  = RW + FRAC_BITS;
  localparam int SW  = (AW + 1) / 2;
  localparam int APW = 2 * SW;
  localparam int RMW = SW + 3;
  localparam int DW  = SW + 1;
  localparam int XW  = (((NUM_W + FRAC_BITS) > (DW + QB)) ? (NUM_W + FRAC_BITS)
                                                          : (DW + QB)) + 1;

  logic en;

  // input register
  logic                   in_v_r;
  logic signed [IN_W-1:0] m_r [9];

  // prep
  logic signed [RW-1:0]   e00, e11, e22, tr, rad;
  logic [RW-1:0]          one;
  rmq_ctl_t               ctl_nxt;
  logic [APW-1:0]         a_nxt;

  // square root stages
  logic                   sq_v_r    [SW+1];
  rmq_ctl_t               sq_ctl_r  [SW+1];
  logic [APW-1:0]         sq_a_r    [SW+1];
  logic [RMW-1:0]         sq_rem_r  [SW+1];
  logic [SW-1:0]          sq_root_r [SW+1];

  // divider stages
  logic                   dv_v_r    [QB+1];
  rmq_ctl_t               dv_ctl_r  [QB+1];
  logic [SW-1:0]          dv_root_r [QB+1];
  logic [DW-1:0]          dv_den_r  [QB+1];
  logic [XW-1:0]          dv_rem_r  [QB+1][NSLOT];
  logic [QB-1:0]          dv_q_r    [QB+1][NSLOT];
  logic                   dv_neg_r  [QB+1][NSLOT];
  logic                   dv_ovf_r  [QB+1][NSLOT];

  // output register
  logic                   out_v_r;
  logic                   out_inv_r;
  logic [OUT_W-1:0]       out_q_r   [NSLOT];
  logic [OUT_W-1:0]       q_nxt     [NSLOT];

  assign en       = !out_v_r || !out_stall;
  assign in_stall = !en;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (en) begin
      in_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_r[0] <= in_r00;
      m_r[1] <= in_r01;
      m_r[2] <= in_r02;
      m_r[3] <= in_r10;
      m_r[4] <= in_r11;
      m_r[5] <= in_r12;
      m_r[6] <= in_r20;
      m_r[7] <= in_r21;
      m_r[8] <= in_r22;
    end
  end

  // branch select, numerators and radicand
  always_comb begin
    e00 = RW'(m_r[0]);
    e11 = RW'(m_r[4]);
    e22 = RW'(m_r[8]);
    one = RW'(1) << FRAC_BITS;
    tr  = e00 + e11 + e22;
    ctl_nxt = '0;
    if (!tr[RW-1]) begin
      rad = tr + $signed(one);
      ctl_nxt.slot[SLOT_W] = 1'b1;
      ctl_nxt.num[SLOT_X]  = NUM_W'(m_r[7]) - NUM_W'(m_r[5]);
      ctl_nxt.num[SLOT_Y]  = NUM_W'(m_r[2]) - NUM_W'(m_r[6]);
      ctl_nxt.num[SLOT_Z]  = NUM_W'(m_r[3]) - NUM_W'(m_r[1]);
    end else if ((e22 > e11) && (e22 > e00)) begin
      rad = e22 - e00 - e11 + $signed(one);
      ctl_nxt.slot[SLOT_Z] = 1'b1;
      ctl_nxt.num[SLOT_W]  = NUM_W'(m_r[3]) - NUM_W'(m_r[1]);
      ctl_nxt.num[SLOT_X]  = NUM_W'(m_r[2]) + NUM_W'(m_r[6]);
      ctl_nxt.num[SLOT_Y]  = NUM_W'(m_r[5]) + NUM_W'(m_r[7]);
    end else if (e11 > e00) begin
      rad = e11 - e22 - e00 + $signed(one);
      ctl_nxt.slot[SLOT_Y] = 1'b1;
      ctl_nxt.num[SLOT_W]  = NUM_W'(m_r[2]) - NUM_W'(m_r[6]);
      ctl_nxt.num[SLOT_Z]  = NUM_W'(m_r[7]) + NUM_W'(m_r[5]);
      ctl_nxt.num[SLOT_X]  = NUM_W'(m_r[1]) + NUM_W'(m_r[3]);
    end else begin
      rad = e00 - e11 - e22 + $signed(one);
      ctl_nxt.slot[SLOT_X] = 1'b1;
      ctl_nxt.num[SLOT_W]  = NUM_W'(m_r[7]) - NUM_W'(m_r[5]);
      ctl_nxt.num[SLOT_Y]  = NUM_W'(m_r[3]) + NUM_W'(m_r[1]);
      ctl_nxt.num[SLOT_Z]  = NUM_W'(m_r[6]) + NUM_W'(m_r[2]);
    end
    ctl_nxt.inv = rad[RW-1] || (rad == '0);
    if (ctl_nxt.inv) begin
      a_nxt = '0;
    end else begin
      a_nxt = APW'({rad, {FRAC_BITS{1'b0}}});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_v_r[0] <= 1'b0;
    end else if (en) begin
      sq_v_r[0] <= in_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_ctl_r[0]  <= ctl_nxt;
      sq_a_r[0]    <= a_nxt;
      sq_rem_r[0]  <= '0;
      sq_root_r[0] <= '0;
    end
  end

  // square root, one result bit per stage
  for (genvar s = 0; s < SW; s++) begin : g_sqrt
    logic [RMW-1:0] rem_sh, trial;

    always_comb begin
      rem_sh = {sq_rem_r[s][RMW-3:0], sq_a_r[s][APW-1-2*s -: 2]};
      trial  = RMW'({sq_root_r[s], 2'b01});
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_v_r[s+1] <= 1'b0;
      end else if (en) begin
        sq_v_r[s+1] <= sq_v_r[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sq_ctl_r[s+1] <= sq_ctl_r[s];
        sq_a_r[s+1]   <= sq_a_r[s];
        if (rem_sh >= trial) begin
          sq_rem_r[s+1]  <= rem_sh - trial;
          sq_root_r[s+1] <= {sq_root_r[s][SW-2:0], 1'b1};
        end else begin
          sq_rem_r[s+1]  <= rem_sh;
          sq_root_r[s+1] <= {sq_root_r[s][SW-2:0], 1'b0};
        end
      end
    end
  end

  // divider setup: magnitude, sign and overflow per lane
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_v_r[0] <= 1'b0;
    end else if (en) begin
      dv_v_r[0] <= sq_v_r[SW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_ctl_r[0]  <= sq_ctl_r[SW];
      dv_root_r[0] <= sq_root_r[SW];
      dv_den_r[0]  <= {sq_root_r[SW], 1'b0};
    end
  end

  for (genvar l = 0; l < NSLOT; l++) begin : g_lane_setup
    logic [NUM_W-1:0] n, mag;
    logic [XW-1:0]    nshift, dlim;

    always_comb begin
      n      = sq_ctl_r[SW].num[l];
      mag    = n[NUM_W-1] ? (~n + NUM_W'(1)) : n;
      nshift = XW'(mag) << FRAC_BITS;
      dlim   = XW'({sq_root_r[SW], 1'b0}) << QB;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_rem_r[0][l] <= nshift;
        dv_q_r[0][l]   <= '0;
        dv_neg_r[0][l] <= n[NUM_W-1];
        dv_ovf_r[0][l] <= (nshift >= dlim);
      end
    end
  end

  // restoring division, one quotient bit per stage
  for (genvar d = 0; d < QB; d++) begin : g_div
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_v_r[d+1] <= 1'b0;
      end else if (en) begin
        dv_v_r[d+1] <= dv_v_r[d];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_ctl_r[d+1]  <= dv_ctl_r[d];
        dv_root_r[d+1] <= dv_root_r[d];
        dv_den_r[d+1]  <= dv_den_r[d];
      end
    end

    for (genvar l = 0; l < NSLOT; l++) begin : g_lane
      logic [XW-1:0] sub;

      assign sub = XW'(dv_den_r[d]) << (QB - 1 - d);

      always_ff @(posedge clk) begin
        if (en) begin
          dv_neg_r[d+1][l] <= dv_neg_r[d][l];
          dv_ovf_r[d+1][l] <= dv_ovf_r[d][l];
          if (dv_rem_r[d][l] >= sub) begin
            dv_rem_r[d+1][l] <= dv_rem_r[d][l] - sub;
            dv_q_r[d+1][l]   <= {dv_q_r[d][l][QB-2:0], 1'b1};
          end else begin
            dv_rem_r[d+1][l] <= dv_rem_r[d][l];
            dv_q_r[d+1][l]   <= {dv_q_r[d][l][QB-2:0], 1'b0};
          end
        end
      end
    end
  end

  // saturation and slot placement
  for (genvar l = 0; l < NSLOT; l++) begin : g_out
    logic [63:0] half;
    logic [QB-1:0] mag;

    always_comb begin
      half = 64'(dv_root_r[QB]) >> 1;
      mag  = dv_q_r[QB][l];
      if (dv_ctl_r[QB].inv) begin
        q_nxt[l] = '0;
      end else if (dv_ctl_r[QB].slot[l]) begin
        q_nxt[l] = (half > 64'(MAG_POS)) ? OUT_MAX : OUT_W'(half);
      end else if (dv_neg_r[QB][l]) begin
        q_nxt[l] = (dv_ovf_r[QB][l] || (mag > MAG_NEG)) ? OUT_MIN
                                                         : OUT_W'(~mag + QB'(1));
      end else begin
        q_nxt[l] = (dv_ovf_r[QB][l] || (mag > MAG_POS)) ? OUT_MAX : OUT_W'(mag);
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        out_q_r[l] <= q_nxt[l];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en) begin
      out_v_r <= dv_v_r[QB];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_inv_r <= dv_ctl_r[QB].inv;
    end
  end

  assign out_valid   = out_v_r;
  assign out_invalid = out_inv_r;
  assign out_qw      = out_q_r[SLOT_W];
  assign out_qx      = out_q_r[SLOT_X];
  assign out_qy      = out_q_r[SLOT_Y];
  assign out_qz      = out_q_r[SLOT_Z];

endmodule

// ===== sim/rotation_matrix_to_quaternion_tb.sv =====
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion_tb
// drives matrices into the quaternion pipeline with random gaps and stalls,
// predicts each quaternion with an independent fixed-point model and checks
// every result transfer in order
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion_tb;

  localparam int FB      = 16;
  localparam int LATENCY = 42;

  typedef logic signed [rmq_pkg::IN_W-1:0] ent_t;
  typedef ent_t mat_t [3][3];

  typedef struct packed {
    logic signed [rmq_pkg::OUT_W-1:0] qw;
    logic signed [rmq_pkg::OUT_W-1:0] qx;
    logic signed [rmq_pkg::OUT_W-1:0] qy;
    logic signed [rmq_pkg::OUT_W-1:0] qz;
    logic                             inv;
  } quat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  ent_t in_r00 = '0, in_r01 = '0, in_r02 = '0;
  ent_t in_r10 = '0, in_r11 = '0, in_r12 = '0;
  ent_t in_r20 = '0, in_r21 = '0, in_r22 = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [rmq_pkg::OUT_W-1:0] out_qw, out_qx, out_qy, out_qz;
  logic out_invalid;

  quat_t expected_quats[$];
  int    mismatches = 0;
  int    hold_len = 0;
  int    held = 0;
  bit    rx_gaps = 1'b1;

  rotation_matrix_to_quaternion dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_r00(in_r00), .in_r01(in_r01), .in_r02(in_r02),
    .in_r10(in_r10), .in_r11(in_r11), .in_r12(in_r12),
    .in_r20(in_r20), .in_r21(in_r21), .in_r22(in_r22),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_qw(out_qw), .out_qx(out_qx), .out_qy(out_qy), .out_qz(out_qz),
    .out_invalid(out_invalid)
  );

  always #5 clk = ~clk;

  function automatic longint unsigned int_root(longint unsigned a);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > a) b >>= 2;
    while (b != 0) begin
      if (a >= r + b) begin
        a -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic logic signed [rmq_pkg::OUT_W-1:0] clamp(longint v);
    if (v < -131072) return rmq_pkg::OUT_MIN;
    if (v > 131071) return rmq_pkg::OUT_MAX;
    return v[rmq_pkg::OUT_W-1:0];
  endfunction

  function automatic quat_t matrix_to_quat(mat_t m);
    longint e[3][3];
    longint q[4];
    longint tr, rad, tt;
    longint unsigned t;
    int i, j, k;
    quat_t res;
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++) e[r][c] = m[r][c];
    q = '{0, 0, 0, 0};
    res = '0;
    tr = e[0][0] + e[1][1] + e[2][2];
    if (tr >= 0) begin
      rad = tr + (64'sd1 <<< FB);
      t = int_root(longint'(rad) << FB);
      tt = 2 * longint'(t);
      q[0] = longint'(t >> 1);
      q[1] = ((e[2][1] - e[1][2]) * (64'sd1 <<< FB)) / tt;
      q[2] = ((e[0][2] - e[2][0]) * (64'sd1 <<< FB)) / tt;
      q[3] = ((e[1][0] - e[0][1]) * (64'sd1 <<< FB)) / tt;
    end else begin
      i = 0;
      if (e[1][1] > e[0][0]) i = 1;
      if (e[2][2] > e[i][i]) i = 2;
      j = (i + 1) % 3;
      k = (j + 1) % 3;
      rad = e[i][i] - e[j][j] - e[k][k] + (64'sd1 <<< FB);
      if (rad <= 0) begin
        res.inv = 1'b1;
        return res;
      end
      t = int_root(longint'(rad) << FB);
      tt = 2 * longint'(t);
      q[i+1] = longint'(t >> 1);
      q[0]   = ((e[k][j] - e[j][k]) * (64'sd1 <<< FB)) / tt;
      q[j+1] = ((e[j][i] + e[i][j]) * (64'sd1 <<< FB)) / tt;
      q[k+1] = ((e[k][i] + e[i][k]) * (64'sd1 <<< FB)) / tt;
    end
    res.qw = clamp(q[0]);
    res.qx = clamp(q[1]);
    res.qy = clamp(q[2]);
    res.qz = clamp(q[3]);
    return res;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
    mismatches++;
  endtask

  function automatic int gap_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    return $urandom_range(0, 2);
  endfunction

  // sender: one matrix per call, held until the transfer
  task automatic send_matrix(mat_t m, bit gaps);
    int g;
    g = gaps ? gap_len() : 0;
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_r00 <= m[0][0]; in_r01 <= m[0][1]; in_r02 <= m[0][2];
    in_r10 <= m[1][0]; in_r11 <= m[1][1]; in_r12 <= m[1][2];
    in_r20 <= m[2][0]; in_r21 <= m[2][1]; in_r22 <= m[2][2];
    expected_quats.insert(expected_quats.size(), matrix_to_quat(m));
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // receiver stall pattern
  always @(negedge clk) begin
    if (held < hold_len) begin
      out_stall <= 1'b1;
      held <= held + 1;
    end else if (rx_gaps) begin
      out_stall <= ($urandom_range(0, 3) == 0) || ($urandom_range(0, 60) == 0);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // result checker
  always @(posedge clk) begin
    quat_t w;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_quats.size() == 0) begin
        report_mismatch("unexpected result", 0, 0);
      end else begin
        w = expected_quats.pop_front();
        if (out_qw !== w.qw) report_mismatch("qw", out_qw, w.qw);
        if (out_qx !== w.qx) report_mismatch("qx", out_qx, w.qx);
        if (out_qy !== w.qy) report_mismatch("qy", out_qy, w.qy);
        if (out_qz !== w.qz) report_mismatch("qz", out_qz, w.qz);
        if (out_invalid !== w.inv) report_mismatch("invalid", out_invalid, w.inv);
      end
    end
  end

  function automatic ent_t rand_ent();
    case ($urandom_range(0, 5))
      0: return ent_t'(-131072);
      1: return ent_t'(131071);
      2: return ent_t'($urandom_range(0, 131072) - 65536);
      default: return ent_t'($urandom);
    endcase
  endfunction

  function automatic mat_t diag(int a, int b, int c);
    mat_t m;
    foreach (m[r, cc]) m[r][cc] = '0;
    m[0][0] = ent_t'(a); m[1][1] = ent_t'(b); m[2][2] = ent_t'(c);
    return m;
  endfunction

  // near-rotation matrix: well-formed diagonal with random off-diagonals within +/-65536
  function automatic mat_t near_rotation();
    mat_t m;
    int s;
    s = $urandom_range(0, 3);
    m = diag(s == 1 ? 65536 : -65536 + $urandom_range(0, 8000),
             s == 2 ? 65536 : -65536 + $urandom_range(0, 8000),
             s == 3 ? 65536 : -65536 + $urandom_range(0, 8000));
    if (s == 0) m = diag($urandom_range(0, 65536), $urandom_range(0, 65536),
                         $urandom_range(0, 65536));
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++)
        if (r != c) m[r][c] = ent_t'($urandom_range(0, 131072) - 65536);
    return m;
  endfunction

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_quats.size() != 0) @(negedge clk);
  endtask

  task automatic test_directed();
    mat_t m;
    send_matrix(diag(65536, 65536, 65536), 1'b0);
    send_matrix(diag(65536, -65536, -65536), 1'b0);
    send_matrix(diag(-65536, 65536, -65536), 1'b0);
    send_matrix(diag(-65536, -65536, 65536), 1'b0);
    send_matrix(diag(-1000, -1000, -1000), 1'b0);
    send_matrix(diag(-65536, -65536, -65536), 1'b0);
    send_matrix(diag(-131072, -131072, -131072), 1'b0);
    send_matrix(diag(131071, 131071, 131071), 1'b0);
    send_matrix(diag(0, 0, 0), 1'b0);
    send_matrix(diag(-1, -1, 0), 1'b0);
    send_matrix(diag(131071, -131072, -131072), 1'b0);
    m = diag(-131072, -131072, 131071);
    foreach (m[r, c]) if (r != c) m[r][c] = (r < c) ? ent_t'(131071) : ent_t'(-131072);
    send_matrix(m, 1'b0);
    m = diag(0, 0, 0);
    foreach (m[r, c]) if (r != c) m[r][c] = (r < c) ? ent_t'(-131072) : ent_t'(131071);
    send_matrix(m, 1'b0);
    m = diag(-131072, 0, 0);
    foreach (m[r, c]) if (r != c) m[r][c] = ent_t'(131071);
    send_matrix(m, 1'b0);
    m = diag(-65536, -65536, -65536);
    foreach (m[r, c]) if (r != c) m[r][c] = ent_t'(-131072);
    send_matrix(m, 1'b0);
    wait_drained();
  endtask

  task automatic test_random(int n);
    mat_t m;
    for (int it = 0; it < n; it++) begin
      if ($urandom_range(0, 3) != 0) m = near_rotation();
      else foreach (m[r, c]) m[r][c] = rand_ent();
      send_matrix(m, 1'b1);
    end
  endtask

  task automatic test_backpressure();
    mat_t m;
    hold_len = 120;
    for (int it = 0; it < 60; it++) begin
      m = near_rotation();
      send_matrix(m, 1'b0);
    end
    wait_drained();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_random(450);
    test_backpressure();
    test_random(500);
    wait_drained();
    rx_gaps = 1'b0;
    repeat (LATENCY + 10) @(negedge clk);
    if (mismatches == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #2000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/rmq_pkg.sv
rtl/rotation_matrix_to_quaternion.sv
sim/rotation_matrix_to_quaternion_tb.sv
